>>> rtl/ttcw_pkg.sv
// Shared constants and types for the text terminal character writer.
package ttcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int MOVE_COUNT = COLUMNS * (ROWS - 1);
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int IDX_W      = 11;
	localparam int CHAR_W     = 8;

	localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0F;
	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
	localparam logic [CHAR_W-1:0] TAB_CHAR     = 8'h09;
	localparam logic [CHAR_W-1:0] HIGH_CHAR    = 8'h80;

	localparam logic FUNC_PUT  = 1'b0;
	localparam logic FUNC_READ = 1'b1;

	// Screen cell: attribute in the high byte, character in the low byte.
	typedef logic [2*CHAR_W-1:0] cell_t;

endpackage

>>> rtl/text_terminal_char_writer.sv
// Text terminal character writer: screen buffer memory, cursor and scroll sequencer.
//
// Usage and timing. The screen lives in one synchronous memory of COLUMNS x ROWS
// cells (80 x 25 = 2000 by default), one read and one write port, read data
// registered. After reset the block sweeps the memory once, writing a space with
// attribute 0x0F into every cell, one cell a cycle: busy stays high for the whole
// sweep and no request is taken, while cfg_wdata/cfg_we writes to the attribute
// register are taken as ever. A request is taken at a clock edge where start is
// high and busy is low. A put request passes through ST_PRINT and ST_REPLY (and
// ST_SCROLL and ST_FLUSH when it scrolls), a read request through ST_READ; each
// answers with a one-cycle done strobe registered in its last state, and busy
// drops in the cycle of that strobe, so a new request can be taken right then.
// A control or high byte is ignored and takes the same path as a put. A tab
// prints four spaces, one per pass through ST_PRINT. When a put moves the
// cursor past the last row the screen scrolls: the sequencer walks the whole
// memory, copying each cell one row up (the cell one row down is read, then
// written from the registered read data) and then blanking the bottom row in
// the current attribute. The result cannot be held off: sample cursor_index,
// cell_char, cell_attr and scrolled in the cycle where done is high.
module text_terminal_char_writer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ttcw_pkg::CHAR_W-1:0]    cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [ttcw_pkg::CHAR_W-1:0]    char_code,
	input  logic [ttcw_pkg::IDX_W-1:0]     read_index,
	output logic                           done,
	output logic [ttcw_pkg::IDX_W-1:0]     cursor_index,
	output logic [ttcw_pkg::CHAR_W-1:0]    cell_char,
	output logic [ttcw_pkg::CHAR_W-1:0]    cell_attr,
	output logic                           scrolled
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRINT,
		ST_SCROLL,
		ST_FLUSH,
		ST_READ,
		ST_REPLY
	} state_t;

	localparam logic [ttcw_pkg::ADDR_W-1:0] LAST_CELL =
		ttcw_pkg::ADDR_W'(ttcw_pkg::CELL_COUNT - 1);
	localparam logic [ttcw_pkg::ADDR_W-1:0] MOVE_END =
		ttcw_pkg::ADDR_W'(ttcw_pkg::MOVE_COUNT);
	localparam logic [ttcw_pkg::ADDR_W-1:0] LAST_ROW_BASE =
		ttcw_pkg::ADDR_W'(ttcw_pkg::MOVE_COUNT);
	localparam logic [ttcw_pkg::ADDR_W-1:0] ROW_STEP =
		ttcw_pkg::ADDR_W'(ttcw_pkg::COLUMNS);
	localparam logic [ttcw_pkg::COL_W-1:0] LAST_COL =
		ttcw_pkg::COL_W'(ttcw_pkg::COLUMNS - 1);
	localparam logic [ttcw_pkg::ROW_W-1:0] LAST_ROW =
		ttcw_pkg::ROW_W'(ttcw_pkg::ROWS - 1);

	// Control and cursor state
	state_t                        state_q;
	logic [ttcw_pkg::CHAR_W-1:0]   attr_q;
	logic [ttcw_pkg::CHAR_W-1:0]   ch_q;
	logic [1:0]                    rep_q;      // spaces still to print after this one (tab)
	logic [ttcw_pkg::COL_W-1:0]    col_q;
	logic [ttcw_pkg::ROW_W-1:0]    row_q;
	logic [ttcw_pkg::ADDR_W-1:0]   addr_q;     // always row_q * COLUMNS + col_q
	logic [ttcw_pkg::ADDR_W-1:0]   scan_q;     // sweep pointer for clear and scroll
	logic                          scrolled_q;
	logic                          oor_q;

	// Scroll copy write stage: the cell read in the cycle before lands one row up, or a bottom-row cell is blanked
	logic                          mv_valid_s1;
	logic                          mv_blank_s1;
	logic [ttcw_pkg::ADDR_W-1:0]   mv_addr_s1;

	// Screen memory
	ttcw_pkg::cell_t               screen_mem [ttcw_pkg::CELL_COUNT];
	ttcw_pkg::cell_t               rd_data_q;
	logic                          mem_we;
	logic [ttcw_pkg::ADDR_W-1:0]   mem_waddr;
	ttcw_pkg::cell_t               mem_wdata;
	logic [ttcw_pkg::ADDR_W-1:0]   mem_raddr;

	logic                          is_nl;
	logic                          printable;
	logic                          last_col;
	logic                          last_row;
	logic [ttcw_pkg::ADDR_W-1:0]   scan_src;

	assign busy      = (state_q != ST_IDLE);
	assign is_nl     = (ch_q == ttcw_pkg::NEWLINE_CHAR);
	assign printable = (ch_q >= ttcw_pkg::SPACE_CHAR) && (ch_q < ttcw_pkg::HIGH_CHAR);
	assign last_col  = (col_q == LAST_COL);
	assign last_row  = (row_q == LAST_ROW);
	// Source of a scroll copy: the same column one row down
	assign scan_src  = ttcw_pkg::ADDR_W'((ttcw_pkg::ADDR_W + 1)'(scan_q) + ROW_STEP);

	// Read address: the requested cell when a request is taken, else the scroll source
	assign mem_raddr = (state_q == ST_IDLE) ? ttcw_pkg::ADDR_W'(read_index) : scan_src;

	// Single write port: clear sweep, scroll stage, or a printed character
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = scan_q;
		mem_wdata = {ttcw_pkg::ATTR_RESET, ttcw_pkg::SPACE_CHAR};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end
		if (mv_valid_s1) begin
			mem_we    = 1'b1;
			mem_waddr = mv_addr_s1;
			mem_wdata = mv_blank_s1 ? {attr_q, ttcw_pkg::SPACE_CHAR} : rd_data_q;
		end
		if (state_q == ST_PRINT && printable) begin
			mem_we    = 1'b1;
			mem_waddr = addr_q;
			mem_wdata = {attr_q, ch_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			screen_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= screen_mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			attr_q       <= ttcw_pkg::ATTR_RESET;
			ch_q         <= '0;
			rep_q        <= '0;
			col_q        <= '0;
			row_q        <= '0;
			addr_q       <= '0;
			scan_q       <= '0;
			scrolled_q   <= 1'b0;
			oor_q        <= 1'b0;
			mv_valid_s1  <= 1'b0;
			mv_blank_s1  <= 1'b0;
			mv_addr_s1   <= '0;
			done         <= 1'b0;
			cursor_index <= '0;
			cell_char    <= '0;
			cell_attr    <= '0;
			scrolled     <= 1'b0;
		end else begin
			done        <= 1'b0;
			mv_valid_s1 <= 1'b0;
			if (cfg_we) begin
				attr_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLEAR: begin
					// Blank one cell a cycle until the whole screen is done
					scan_q <= scan_q + 1'b1;
					if (scan_q == LAST_CELL) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						scrolled_q <= 1'b0;
						if (func == ttcw_pkg::FUNC_READ) begin
							oor_q   <= (32'(read_index) >= ttcw_pkg::CELL_COUNT);
							state_q <= ST_READ;
						end else if (char_code == ttcw_pkg::TAB_CHAR) begin
							// Tab: four spaces, each through wrap and scroll
							ch_q    <= ttcw_pkg::SPACE_CHAR;
							rep_q   <= 2'd3;
							state_q <= ST_PRINT;
						end else begin
							ch_q    <= char_code;
							rep_q   <= 2'd0;
							state_q <= ST_PRINT;
						end
					end
				end
				ST_PRINT: begin
					if (!is_nl && !printable) begin
						// Control or high byte: drop it, cursor stays
						state_q <= ST_REPLY;
					end else if (!is_nl && !last_col) begin
						col_q  <= col_q + 1'b1;
						addr_q <= addr_q + 1'b1;
						if (rep_q != 2'd0) begin
							rep_q <= rep_q - 1'b1;
						end else begin
							state_q <= ST_REPLY;
						end
					end else if (!last_row) begin
						// Wrap to the start of the next row
						col_q  <= '0;
						row_q  <= row_q + 1'b1;
						addr_q <= addr_q + ROW_STEP - ttcw_pkg::ADDR_W'(col_q);
						if (rep_q != 2'd0) begin
							rep_q <= rep_q - 1'b1;
						end else begin
							state_q <= ST_REPLY;
						end
					end else begin
						// Past the last row: hold on the last row and scroll
						col_q      <= '0;
						addr_q     <= LAST_ROW_BASE;
						scrolled_q <= 1'b1;
						scan_q     <= '0;
						state_q    <= ST_SCROLL;
					end
				end
				ST_SCROLL: begin
					// Copy cells up one row, then blank the bottom row
					mv_valid_s1 <= 1'b1;
					mv_addr_s1  <= scan_q;
					mv_blank_s1 <= (scan_q >= MOVE_END);
					scan_q      <= scan_q + 1'b1;
					if (scan_q == LAST_CELL) begin
						scan_q  <= '0;
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					// Last blank write drains this cycle
					if (rep_q != 2'd0) begin
						rep_q   <= rep_q - 1'b1;
						state_q <= ST_PRINT;
					end else begin
						state_q <= ST_REPLY;
					end
				end
				ST_READ: begin
					cursor_index <= ttcw_pkg::IDX_W'(addr_q);
					cell_char    <= oor_q ? '0 : rd_data_q[ttcw_pkg::CHAR_W-1:0];
					cell_attr    <= oor_q ? '0 : rd_data_q[2*ttcw_pkg::CHAR_W-1:ttcw_pkg::CHAR_W];
					scrolled     <= 1'b0;
					done         <= 1'b1;
					state_q      <= ST_IDLE;
				end
				ST_REPLY: begin
					cursor_index <= ttcw_pkg::IDX_W'(addr_q);
					cell_char    <= '0;
					cell_attr    <= '0;
					scrolled     <= scrolled_q;
					done         <= 1'b1;
					state_q      <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Cursor stays on the screen
	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < ttcw_pkg::COLUMNS) && (32'(row_q) < ttcw_pkg::ROWS))
		else $error("cursor left the screen");

	// Linear cursor address tracks row and column
	a_addr_track: assert property (@(posedge clk) disable iff (!arst_n)
		32'(addr_q) == 32'(row_q) * ttcw_pkg::COLUMNS + 32'(col_q))
		else $error("cursor address out of step with row and column");

	// A taken request makes the block busy on the next cycle
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	// One strobe per request, never two in a row
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A scroll report never carries cell data
	a_scroll_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> (cell_char == '0 && cell_attr == '0))
		else $error("scrolled result carries cell data");
`endif

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the text terminal character writer.
module tb_top;
	import ttcw_pkg::*;

	// One answer of the block, as sampled on the cycle where done is high.
	typedef struct packed {
		logic [IDX_W-1:0]  cursor_index;
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
		logic              scrolled;
	} answer_t;

	// One row of the directed stimulus; typed rows carry their answer.
	typedef struct {
		logic              func;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		bit                typed;
		answer_t           ans;
	} directed_row_t;

	localparam int TAB_SPACES     = 4;
	localparam int REPORT_LIMIT   = 10;
	localparam int PHASE_COUNT    = 6;
	localparam int PHASE_REQUESTS = 272;
	localparam int QUIET_PHASE    = 2;
	localparam int DONE_LATENCY   = 4;
	localparam int DRAIN_LIMIT    = 20000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [CHAR_W-1:0] cfg_wdata = '0;
	logic              start = 1'b0;
	logic              func = FUNC_PUT;
	logic [CHAR_W-1:0] char_code = '0;
	logic [IDX_W-1:0]  read_index = '0;
	logic              busy;
	logic              done;
	logic [IDX_W-1:0]  cursor_index;
	logic [CHAR_W-1:0] cell_char;
	logic [CHAR_W-1:0] cell_attr;
	logic              scrolled;

	// Hand-written answer that travels with a directed request.
	bit                req_typed = 1'b0;
	answer_t           req_typed_answer = '0;

	// Shadow copy of the screen, cursor and attribute register.
	cell_t             shadow_screen [CELL_COUNT];
	int                shadow_col;
	int                shadow_row;
	logic [CHAR_W-1:0] shadow_attr;

	answer_t           pending_answers [$];
	directed_row_t     directed_rows [$];

	int mismatches  = 0;
	int answers_got = 0;
	int puts_taken  = 0;
	int reads_taken = 0;
	int scrolls_hit = 0;
	int attr_writes = 0;

	text_terminal_char_writer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.char_code    (char_code),
		.read_index   (read_index),
		.done         (done),
		.cursor_index (cursor_index),
		.cell_char    (cell_char),
		.cell_attr    (cell_attr),
		.scrolled     (scrolled)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Fixed ceiling on the whole run; far above the slowest legal run.
	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Wrap the cursor at the right edge; scroll when it falls off the bottom.
	function automatic bit shadow_settle();
		if (shadow_col >= COLUMNS) begin
			shadow_col = 0;
			shadow_row++;
		end
		if (shadow_row >= ROWS) begin
			shadow_row = ROWS - 1;
			for (int i = 0; i < MOVE_COUNT; i++)
				shadow_screen[i] = shadow_screen[i + COLUMNS];
			for (int k = 0; k < COLUMNS; k++)
				shadow_screen[MOVE_COUNT + k] = {shadow_attr, SPACE_CHAR};
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Print one byte; control and high bytes leave everything alone.
	function automatic bit shadow_print(logic [CHAR_W-1:0] ch);
		if (ch == NEWLINE_CHAR) begin
			shadow_col = COLUMNS;
		end else if (ch < SPACE_CHAR || ch >= HIGH_CHAR) begin
			return 1'b0;
		end else begin
			shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, ch};
			shadow_col++;
		end
		return shadow_settle();
	endfunction

	// Advance the shadow by one request and return the answer it must give.
	function automatic answer_t predict_answer(logic f, logic [CHAR_W-1:0] ch,
			logic [IDX_W-1:0] idx);
		answer_t a;
		int      pos;
		bit      s;
		a = '0;
		if (f == FUNC_PUT) begin
			if (ch == TAB_CHAR) begin
				for (int k = 0; k < TAB_SPACES; k++) begin
					s = shadow_print(SPACE_CHAR);
					a.scrolled = a.scrolled | s;
				end
			end else begin
				a.scrolled = shadow_print(ch);
			end
		end else if (idx < CELL_COUNT) begin
			a.cell_char = shadow_screen[idx][CHAR_W-1:0];
			a.cell_attr = shadow_screen[idx][2*CHAR_W-1:CHAR_W];
		end
		pos = shadow_row * COLUMNS + shadow_col;
		a.cursor_index = pos[IDX_W-1:0];
		return a;
	endfunction

	// Check answers against the oldest expectation, then queue the expectation
	// of any request taken on this edge. Everything here samples pre-edge values.
	always @(posedge clk) begin : check_answers
		answer_t got;
		answer_t want;
		if (arst_n) begin
			if (done) begin
				got.cursor_index = cursor_index;
				got.cell_char    = cell_char;
				got.cell_attr    = cell_attr;
				got.scrolled     = scrolled;
				answers_got++;
				if (pending_answers.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: answer with nothing expected: cur=%0d ch=%h at=%h sc=%b",
							$time, got.cursor_index, got.cell_char, got.cell_attr,
							got.scrolled);
				end else begin
					want = pending_answers.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("%0t: mismatch exp cur=%0d ch=%h at=%h sc=%b, got cur=%0d ch=%h at=%h sc=%b",
								$time, want.cursor_index, want.cell_char, want.cell_attr,
								want.scrolled, got.cursor_index, got.cell_char,
								got.cell_attr, got.scrolled);
					end
				end
			end
			if (cfg_we)
				shadow_attr = cfg_wdata;
			if (start && !busy) begin
				want = predict_answer(func, char_code, read_index);
				if (func == FUNC_PUT)
					puts_taken++;
				else
					reads_taken++;
				if (want.scrolled)
					scrolls_hit++;
				if (req_typed)
					want = req_typed_answer;
				pending_answers.push_back(want);
			end
		end
	end

	task automatic add_row(logic f, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx,
			bit typed, int cur, logic [CHAR_W-1:0] cc, logic [CHAR_W-1:0] ca,
			logic sc);
		directed_row_t r;
		r.func = f;
		r.ch = ch;
		r.idx = idx;
		r.typed = typed;
		r.ans.cursor_index = cur[IDX_W-1:0];
		r.ans.cell_char = cc;
		r.ans.cell_attr = ca;
		r.ans.scrolled = sc;
		directed_rows.push_back(r);
	endtask

	// Present one request and hold it until the block takes it. Called right
	// after a rising edge; an optional gap comes first so start never drops and
	// rises in the same step.
	task automatic send_request(logic f, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx,
			bit typed, answer_t ans, bit may_idle);
		if (may_idle && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start            <= 1'b1;
		func             <= f;
		char_code        <= ch;
		read_index       <= idx;
		req_typed        <= typed;
		req_typed_answer <= ans;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Drop start and let every outstanding answer come home before touching
	// the attribute register.
	task automatic wait_drained();
		int n;
		n = 0;
		start <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (DONE_LATENCY) @(posedge clk);
	endtask

	task automatic write_attr(logic [CHAR_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		attr_writes++;
	endtask

	initial begin : stimulus
		logic [CHAR_W-1:0] phase_attr [PHASE_COUNT];
		logic              f;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
		int                pick;
		bit                idle_ok;

		for (int i = 0; i < CELL_COUNT; i++)
			shadow_screen[i] = {ATTR_RESET, SPACE_CHAR};
		shadow_attr = ATTR_RESET;
		shadow_col = 0;
		shadow_row = 0;

		// Hold reset, release it on an edge, then wait out the
		// clearing sweep of the screen memory.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		// Directed part at the reset attribute: edges of the read range,
		// ignored bytes, printable extremes, tab and newline.
		add_row(FUNC_READ, 8'h00, 11'd0,    1, 0, SPACE_CHAR, ATTR_RESET, 0);
		add_row(FUNC_READ, 8'hFF, 11'd1999, 1, 0, SPACE_CHAR, ATTR_RESET, 0);
		add_row(FUNC_READ, 8'h00, 11'd2000, 1, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_READ, 8'h00, 11'd2047, 1, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'h00, 11'd0,    1, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'h1F, 11'd2047, 1, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  HIGH_CHAR, 11'd0, 1, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'hFF, 11'd0,    1, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  SPACE_CHAR, 11'd0, 1, 1, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'h41, 11'd0,    1, 2, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'h7F, 11'd0,    1, 3, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'h7E, 11'd0,    0, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_READ, 8'h00, 11'd1,    1, 4, 8'h41, ATTR_RESET, 0);
		add_row(FUNC_PUT,  TAB_CHAR, 11'd0, 0, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  NEWLINE_CHAR, 11'd0, 1, COLUMNS, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  NEWLINE_CHAR, 11'd0, 0, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_PUT,  8'h0D, 11'd0,    0, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_READ, 8'h00, 11'd2,    1, 2 * COLUMNS, 8'h7F, ATTR_RESET, 0);
		add_row(FUNC_READ, 8'h00, 11'd5,    0, 0, 8'h00, 8'h00, 0);
		add_row(FUNC_READ, 8'h00, 11'd1024, 0, 0, 8'h00, 8'h00, 0);
		foreach (directed_rows[i])
			send_request(directed_rows[i].func, directed_rows[i].ch, directed_rows[i].idx,
				directed_rows[i].typed, directed_rows[i].ans, 1'b1);

		// Random phases, each under its own attribute: both extremes first,
		// then alternating bit patterns and two random values.
		phase_attr[0] = 8'h00;
		phase_attr[1] = 8'hFF;
		phase_attr[2] = 8'hA5;
		phase_attr[3] = 8'h5A;
		phase_attr[4] = 8'($urandom);
		phase_attr[5] = 8'($urandom);
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_drained();
			write_attr(phase_attr[p]);
			// One phase runs back to back with no gaps at all.
			idle_ok = (p != QUIET_PHASE);
			for (int n = 0; n < PHASE_REQUESTS; n++) begin
				pick = $urandom_range(0, 99);
				f    = FUNC_PUT;
				ch   = 8'($urandom);
				idx  = 11'($urandom);
				if (pick < 58) begin
					ch = 8'($urandom_range(SPACE_CHAR, HIGH_CHAR - 1));
				end else if (pick < 66) begin
					ch = NEWLINE_CHAR;
				end else if (pick < 71) begin
					ch = TAB_CHAR;
				end else if (pick < 74) begin
					ch = 8'($urandom_range(0, SPACE_CHAR - 1));
				end else if (pick < 77) begin
					ch = 8'($urandom_range(HIGH_CHAR, 8'hFF));
				end else begin
					// Reads: half anywhere in the address space, half in the
					// bottom rows where scrolling leaves its traces.
					f = FUNC_READ;
					if ($urandom_range(0, 1))
						idx = 11'($urandom_range(CELL_COUNT - 3 * COLUMNS, CELL_COUNT - 1));
				end
				send_request(f, ch, idx, 1'b0, '0, idle_ok);
			end
		end

		wait_drained();
		if (pending_answers.size() != 0) begin
			mismatches += pending_answers.size();
			$display("%0d expected answers never arrived", pending_answers.size());
		end

		$display("Ran %0d puts and %0d reads (%0d answers), %0d of them scrolling the screen.",
			puts_taken, reads_taken, answers_got, scrolls_hit);
		$display("Used %0d attribute settings; %0d mismatches.", attr_writes + 1, mismatches);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/ttcw_pkg.sv
rtl/text_terminal_char_writer.sv
test/tb_top.sv
